// File: rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] CLAMP_CP = 21'h00003F;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] PAY2_MASK  = 8'h1F;
  localparam logic [7:0] PAY3_MASK  = 8'h0F;
  localparam logic [7:0] PAY4_MASK  = 8'h07;

  // Work for the back end: rep_cnt replacements, then an optional value.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic            has_val;
    logic [CP_W-1:0] val;
    logic            str_end;
  } u8d_job_t;

endpackage

// File: rtl/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, tracks the open sequence and turns each byte that yields results into a job.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            astral_clamp,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      data_byte,
  input  logic            string_end,
  input  logic            q_full,
  output logic            push,
  output u8d_pkg::u8d_job_t push_job
);
  import u8d_pkg::*;

  logic [14:0] partial;
  logic [1:0]  rem;
  logic [1:0]  ct;
  logic [14:0] partial_next;
  logic [1:0]  rem_next;
  logic [1:0]  ct_next;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    logic            is_cont;
    logic            fresh;
    logic [CP_W-1:0] cp;
    logic [1:0]      rem_dec;

    is_cont        = (data_byte & CONT_MASK) == CONT_CODE;
    fresh          = 1'b1;
    cp             = {partial, data_byte[5:0]};
    rem_dec        = rem - 2'd1;
    partial_next   = partial;
    rem_next       = rem;
    ct_next        = ct;
    push_job       = '0;
    push_job.str_end = string_end;

    if (rem != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (rem_dec == 2'd0) begin
          push_job.has_val = 1'b1;
          push_job.val     = (astral_clamp && (|cp[20:16])) ? CLAMP_CP : cp;
          partial_next     = '0;
          rem_next         = 2'd0;
          ct_next          = 2'd0;
        end else begin
          partial_next = cp[14:0];
          rem_next     = rem_dec;
          ct_next      = ct + 2'd1;
        end
      end else begin
        // broken sequence: flush lead and taken continuations
        push_job.rep_cnt = {1'b0, ct} + 3'd1;
        partial_next     = '0;
        rem_next         = 2'd0;
        ct_next          = 2'd0;
      end
    end

    if (fresh) begin
      priority if (!data_byte[7]) begin
        push_job.has_val = 1'b1;
        push_job.val     = {13'd0, data_byte};
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
        partial_next = {7'd0, data_byte & PAY2_MASK};
        rem_next     = 2'd1;
        ct_next      = 2'd0;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
        partial_next = {7'd0, data_byte & PAY3_MASK};
        rem_next     = 2'd2;
        ct_next      = 2'd0;
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
        partial_next = {7'd0, data_byte & PAY4_MASK};
        rem_next     = 2'd3;
        ct_next      = 2'd0;
      end else begin
        push_job.rep_cnt = push_job.rep_cnt + 3'd1;
      end
    end

    // string ends with a sequence still open
    if (string_end && rem_next != 2'd0) begin
      push_job.rep_cnt = push_job.rep_cnt + {1'b0, ct_next} + 3'd1;
      partial_next     = '0;
      rem_next         = 2'd0;
      ct_next          = 2'd0;
    end
  end

  assign push = accept & ((push_job.rep_cnt != 3'd0) | push_job.has_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      rem     <= '0;
      ct      <= '0;
    end else if (accept) begin
      partial <= partial_next;
      rem     <= rem_next;
      ct      <= ct_next;
    end
  end

endmodule

// File: rtl/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue
// Small job queue between the front and back ends.
// ----------------------------------------------------------------------------
module u8d_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8d_pkg::u8d_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8d_pkg::u8d_job_t head_job
);
  import u8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u8d_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == FULL_CNT;
  assign head_valid = count != '0;
  assign head_job   = mem[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Expands queued jobs into code points, one per cycle while out_stall does not hold the output register.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  u8d_pkg::u8d_job_t head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [20:0]       code_point,
  output logic              replaced,
  output logic              run_last,
  output logic              string_last
);
  import u8d_pkg::*;

  logic [2:0] sent;
  logic [2:0] total;
  logic       can_load;
  logic       fire;
  logic       is_rep;
  logic       is_last;

  assign total    = head_job.rep_cnt + {2'd0, head_job.has_val};
  assign can_load = ~out_valid | ~out_stall;
  assign fire     = head_valid & can_load;
  assign is_rep   = sent < head_job.rep_cnt;
  assign is_last  = sent == (total - 3'd1);
  assign pop      = fire & is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        sent <= is_last ? 3'd0 : sent + 3'd1;
      end
      if (can_load) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      code_point  <= is_rep ? REPL_CP : head_job.val;
      replaced    <= is_rep;
      run_last    <= is_last;
      string_last <= is_last & head_job.str_end;
    end
  end

endmodule

// File: rtl/utf8_codepoint_decoder_core.sv
// Path: an accepted byte's job is written into the job queue, then its first result is registered at the outputs.
// Throughput: one byte per cycle while the job queue is not full, and one result per
// cycle while out_stall is low; a byte that causes several replacements holds the result
// side until all are sent, and the job queue (QUEUE_DEPTH entries) absorbs such bursts before input stalls.
// Reset: no sequence open, queue and output register empty, astral_clamp = 1.
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_core
// Streaming UTF-8 byte to code point decoder with optional astral clamp.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        replaced,
  output logic        run_last,
  output logic        string_last
);
  import u8d_pkg::*;

  logic     astral_clamp;
  logic     q_full;
  logic     push;
  u8d_job_t push_job;
  logic     pop;
  logic     head_valid;
  u8d_job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      astral_clamp <= 1'b1;
    end else if (cfg_wr_en) begin
      astral_clamp <= cfg_wr_data;
    end
  end

  u8d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .astral_clamp (astral_clamp),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .string_end   (string_end),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .replaced    (replaced),
    .run_last    (run_last),
    .string_last (string_last)
  );

endmodule

// File: test/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches the byte and code point channels of the UTF-8 decoder, predicts the
// code points each accepted byte produces and compares them in order.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [7:0]               data_byte,
  input  logic                     string_end,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [u8d_pkg::CP_W-1:0] code_point,
  input  logic                     replaced,
  input  logic                     run_last,
  input  logic                     string_last,
  output int                       errors,
  output int                       pending
);
  import u8d_pkg::*;

  localparam logic [CP_W-1:0] BMP_MAX = 21'h00FFFF;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            repl;
    logic            rlast;
    logic            slast;
  } cp_result_t;

  cp_result_t  expected_cps[$];
  cp_result_t  byte_cps[$];
  cp_result_t  got;
  cp_result_t  want;

  // decoder state mirror
  logic [14:0] open_bits;
  logic [1:0]  conts_needed;
  logic [1:0]  conts_seen;
  logic        clamp_en;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic push_cp(input logic [CP_W-1:0] cp, input logic repl);
    byte_cps.push_back({cp, repl, 1'b0, 1'b0});
  endtask

  task automatic close_open_seq();
    open_bits    = '0;
    conts_needed = '0;
    conts_seen   = '0;
  endtask

  // lead and every continuation taken so far become U+FFFD
  task automatic flush_broken_seq();
    repeat (1 + conts_seen) push_cp(REPL_CP, 1'b1);
    close_open_seq();
  endtask

  task automatic decode_lead(input logic [7:0] b);
    if (!b[7]) begin
      push_cp({13'b0, b}, 1'b0);
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      open_bits    = 15'(b & PAY2_MASK);
      conts_needed = 2'd1;
      conts_seen   = '0;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      open_bits    = 15'(b & PAY3_MASK);
      conts_needed = 2'd2;
      conts_seen   = '0;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      open_bits    = 15'(b & PAY4_MASK);
      conts_needed = 2'd3;
      conts_seen   = '0;
    end else begin
      // stray continuation or invalid lead
      push_cp(REPL_CP, 1'b1);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [CP_W-1:0] acc;
    cp_result_t      r;
    byte_cps.delete();
    if (conts_needed != 0) begin
      if ((b & CONT_MASK) == CONT_CODE) begin
        acc          = {open_bits, b[5:0]};
        conts_needed = conts_needed - 2'd1;
        if (conts_needed == 0) begin
          if (clamp_en && acc > BMP_MAX) acc = CLAMP_CP;
          push_cp(acc, 1'b0);
          close_open_seq();
        end else begin
          open_bits  = acc[14:0];
          conts_seen = conts_seen + 2'd1;
        end
      end else begin
        flush_broken_seq();
        decode_lead(b);
      end
    end else begin
      decode_lead(b);
    end
    if (fin && conts_needed != 0) flush_broken_seq();
    foreach (byte_cps[i]) begin
      r = byte_cps[i];
      if (i == byte_cps.size() - 1) begin
        r.rlast = 1'b1;
        r.slast = fin;
      end
      expected_cps.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      close_open_seq();
      clamp_en = 1'b1;
      expected_cps.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {code_point, replaced, run_last, string_last};
        if (expected_cps.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected code point transaction cp=%h repl=%b run=%b str=%b",
                     code_point, replaced, run_last, string_last);
          errors++;
        end else begin
          want = expected_cps.pop_front();
          if (got != want) begin
            if (errors < 10)
              $display("ERROR: cp %h/%h repl %b/%b run_last %b/%b string_last %b/%b (exp/act)",
                       want.cp, got.cp, want.repl, got.repl, want.rlast, got.rlast,
                       want.slast, got.slast);
            errors++;
          end
        end
      end
      if (cfg_wr_en) clamp_en = cfg_wr_data;
      if (in_valid && !in_stall) predict_byte(data_byte, string_end);
    end
    pending = expected_cps.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 strings into the decoder: directed edge cases, then random
// well-formed strings with injected breakage, under both clamp settings and
// random idle/stall on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import u8d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wr_en = 1'b0;
  logic            cfg_wr_data = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      data_byte = '0;
  logic            string_end = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CP_W-1:0] code_point;
  logic            replaced;
  logic            run_last;
  logic            string_last;

  int              mismatches;
  int              in_flight;
  int              cycle_count = 0;
  int              bytes_sent = 0;
  int              stall_hold = 0;
  logic            in_taken = 1'b0;
  logic            no_idle = 1'b0;
  logic [7:0]      str_bytes[$];

  utf8_codepoint_decoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .replaced    (replaced),
    .run_last    (run_last),
    .string_last (string_last)
  );

  utf8_decode_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .replaced    (replaced),
    .run_last    (run_last),
    .string_last (string_last),
    .errors      (mismatches),
    .pending     (in_flight)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    in_taken    <= in_valid && !in_stall;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_codepoint_decoder_core: mismatch");
      $finish;
    end
  end

  // receiver backpressure: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (rst || no_idle) begin
      out_stall  = 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall  = 1'b0;
          stall_hold = $urandom_range(0, 8);
        end
        9: begin
          out_stall  = 1'b1;
          stall_hold = $urandom_range(5, 30);
        end
        default: begin
          out_stall  = 1'b1;
          stall_hold = $urandom_range(0, 2);
        end
      endcase
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_byte  = b;
    string_end = fin;
    in_valid   = 1'b1;
    do @(negedge clk); while (!in_taken);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic set_clamp(input logic v);
    wait_drained();
    repeat (6) @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // one string of random code points, with occasional breakage
  task automatic send_random_string();
    int n_cps;
    int n_cont;
    int n_keep;
    logic [7:0] lead;
    str_bytes.delete();
    n_cps = $urandom_range(1, 8);
    repeat (n_cps) begin
      case ($urandom_range(0, 24))
        0: str_bytes.push_back(CONT_CODE | 8'($urandom_range(0, 63)));
        1: str_bytes.push_back(LEAD4_MASK | 8'($urandom_range(0, 7)));
        2: str_bytes.push_back(8'($urandom_range(0, 255)));
        default: begin
          n_cont = $urandom_range(0, 3);
          case (n_cont)
            0: lead = 8'($urandom_range(0, 127));
            1: lead = LEAD2_CODE | (8'($urandom) & PAY2_MASK);
            2: lead = LEAD3_CODE | (8'($urandom) & PAY3_MASK);
            default: lead = LEAD4_CODE | (8'($urandom) & PAY4_MASK);
          endcase
          n_keep = n_cont;
          if (n_cont > 0 && $urandom_range(0, 9) == 0) n_keep = $urandom_range(0, n_cont - 1);
          str_bytes.push_back(lead);
          repeat (n_keep) str_bytes.push_back(CONT_CODE | 8'($urandom_range(0, 63)));
        end
      endcase
    end
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  task automatic run_random(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_string();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // clamp at reset value (on)
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    // astral value clamped to '?'
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    // stray continuations and invalid leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // missing continuation, offending byte decoded again
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b1);
    // string ends mid-sequence
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b1);
    // broken 4-byte sequence, new lead then end of string: four replacements
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b1);

    set_clamp(1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);

    run_random(50);
    wait_drained();
    run_random(55);

    set_clamp(1'b1);
    no_idle = 1'b1;
    run_random(30);
    no_idle = 1'b0;
    run_random(70);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("utf8_codepoint_decoder_core: match");
    else
      $display("utf8_codepoint_decoder_core: mismatch");
    $finish;
  end

endmodule

// File: utf8_codepoint_decoder_core.f
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_codepoint_decoder_core.sv
test/utf8_decode_checker.sv
test/testbench.sv
